@@ rtl/ldfd_pkg.sv @@
// Shared types and constants for the laser distance frame decoder.
`default_nettype none

package ldfd_pkg;

  localparam int RX_W   = 8;
  localparam int PART_W = 6;
  localparam int TOP_W  = 4;
  localparam int RAW_W  = 16;
  localparam int DIST_W = 16;
  localparam int CNT_W  = 8;
  localparam int CFG_W  = 16;
  localparam int CFG_IDX_W = 2;

  localparam int FRAC_BITS_DEF = 8;

  // Tag bits of a received byte
  localparam int TAG_HIGH_BIT = 7;
  localparam int TAG_MID_BIT  = 6;

  localparam logic [RAW_W-1:0] ERROR_CODE  = 16'd65467;
  localparam logic [RAW_W-1:0] MIDDLE_CODE = ERROR_CODE / 16'd2;

  // distance = (raw*102 - 65520) * 2^F / 131040, and 131040 = 4095 << 5
  localparam int SCALE_MUL   = 102;
  localparam int ZERO_OFFSET = 65520;
  localparam int HALF_DEN    = 65520;
  localparam int DEN_SHIFT   = 5;
  localparam int DEN_LOG     = 12;
  localparam int DEN_ODD     = (1 << DEN_LOG) - 1;

  // Signed numerator raw*102 - 65520 fits 24 bits; its magnitude 23
  localparam int NUM_W = 24;
  localparam int MAG_W = NUM_W - 1;

  localparam logic [CFG_IDX_W-1:0] CFG_ERR_LIMIT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_HIGH_DIST = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_LOW_DIST  = 2'd2;

  localparam logic [CNT_W-1:0]  ERR_LIMIT_RST = 8'd100;
  localparam logic [DIST_W-1:0] HIGH_DIST_RST = 16'd12930;
  localparam logic [DIST_W-1:0] LOW_DIST_RST  = 16'hFF80;

  typedef enum logic [1:0] {
    ST_VALID    = 2'd0,
    ST_REPORTED = 2'd1,
    ST_IGNORED  = 2'd2
  } status_t;

  // One completed sample on its way to the output stage
  typedef struct packed {
    logic [RAW_W-1:0] raw;
    status_t          status;
    logic             sel_high;
    logic             neg;
    logic [MAG_W-1:0] mag;
  } conv_req_t;

endpackage

`default_nettype wire

@@ rtl/ldfd_conv.sv @@
// Scaled, rounded and saturated conversion of the raw numerator to Q distance.
`default_nettype none

module ldfd_conv #(
  parameter int FRAC_BITS = ldfd_pkg::FRAC_BITS_DEF
) (
  input  wire logic                            neg,
  input  wire logic [ldfd_pkg::MAG_W-1:0]      mag,
  output logic signed [ldfd_pkg::DIST_W-1:0]   q_dist
);
  import ldfd_pkg::*;

  localparam int SH_W  = MAG_W + FRAC_BITS + 1;
  localparam int U_W   = SH_W - DEN_SHIFT;
  localparam int Q_W   = U_W + 1 - DEN_LOG;
  localparam int CMP_W = (Q_W > DIST_W) ? Q_W + 1 : DIST_W + 1;

  logic [SH_W-1:0]   t;
  logic [U_W-1:0]    u;
  logic [U_W:0]      acc;
  logic [Q_W-1:0]    est;
  logic [U_W:0]      prod;
  logic [U_W:0]      rem;
  logic [Q_W-1:0]    q;
  logic [CMP_W-1:0]  qx;
  logic [CMP_W-1:0]  lim;
  logic [CMP_W-1:0]  qs;
  logic [DIST_W-1:0] qlow;

  always_comb begin
    // round half away: |n|*2^F + den/2, then floor divide by 131040
    t    = (SH_W'(mag) << FRAC_BITS) + SH_W'(HALF_DEN);
    u    = t[SH_W-1:DEN_SHIFT];
    // 1/4095 ~ (1 + 2^-12 + 2^-24) / 4096; estimate is exact or one short
    acc  = (U_W+1)'(u) + (U_W+1)'(u >> DEN_LOG) + (U_W+1)'(u >> (2 * DEN_LOG));
    est  = acc[U_W:DEN_LOG];
    prod = {est, {DEN_LOG{1'b0}}} - (U_W+1)'(est);
    rem  = (U_W+1)'(u) - prod;
    q    = est + Q_W'(rem >= (U_W+1)'(DEN_ODD));
    qx   = CMP_W'(q);
    lim  = neg ? CMP_W'(1 << (DIST_W - 1)) : CMP_W'((1 << (DIST_W - 1)) - 1);
    qs   = (qx > lim) ? lim : qx;
    qlow = qs[DIST_W-1:0];
    q_dist = neg ? $signed(-qlow) : $signed(qlow);
  end

endmodule

`default_nettype wire

@@ rtl/laser_distance_frame_decoder.sv @@
// Top level of the laser distance frame decoder.
// Usage:
//   Input channel (in_valid / in_stall / in_rx_byte) takes one received serial
//   byte per request. Tag bits 7:6 = 00 store the low six bits, 01 the middle
//   six bits; bit 7 set supplies the top four bits and completes a sample.
//   Only completing bytes produce a result request on the output channel
//   (out_valid / out_stall) with raw value, Q distance and status.
//   A completing byte passes through assembly and numerator ahead of the middle
//   register, then constant divide, rounding and result select ahead of the
//   output register. Throughput: one byte per cycle while in_stall is low.
//   Stall: a result held by out_stall stays put; one more sample can wait in
//   the middle stage, after which in_stall rises until the output drains.
//   Low- and middle-part bytes are always taken unless in_stall is high.
//   Configuration: cfg_wr_en writes register cfg_index (0 error limit,
//   1 high error distance, 2 low error distance) from cfg_wr_data; index 3
//   is ignored. Write only while no request is in flight.
//   Reset (rst_n low, synchronous): empties both stages, clears the stored
//   parts, error counter, last good sample and held distance, and loads the
//   default configuration. No clearing pass; the block is ready next cycle.
`default_nettype none

module laser_distance_frame_decoder #(
  parameter int FRAC_BITS = ldfd_pkg::FRAC_BITS_DEF
) (
  input  wire logic                                 clk,
  input  wire logic                                 rst_n,
  input  wire logic                                 in_valid,
  output logic                                      in_stall,
  input  wire logic [ldfd_pkg::RX_W-1:0]            in_rx_byte,
  output logic                                      out_valid,
  input  wire logic                                 out_stall,
  output logic [ldfd_pkg::RAW_W-1:0]                out_raw_value,
  output logic signed [ldfd_pkg::DIST_W-1:0]        out_distance_q8,
  output logic [1:0]                                out_sample_status,
  input  wire logic                                 cfg_wr_en,
  input  wire logic [ldfd_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  wire logic [ldfd_pkg::CFG_W-1:0]           cfg_wr_data
);
  import ldfd_pkg::*;

  // configuration
  logic [CNT_W-1:0]         err_limit_r;
  logic signed [DIST_W-1:0] high_dist_r;
  logic signed [DIST_W-1:0] low_dist_r;

  // decoder state
  logic [PART_W-1:0] low_bits_r,  low_bits_nxt;
  logic [PART_W-1:0] mid_bits_r,  mid_bits_nxt;
  logic [CNT_W-1:0]  err_cnt_r,   err_cnt_nxt;
  logic [RAW_W-1:0]  last_good_r, last_good_nxt;
  logic signed [DIST_W-1:0] held_dist_r;

  // middle stage
  conv_req_t p1_r, p1_nxt;
  logic      p1_valid_r, p1_valid_nxt;

  // output stage
  logic                     out_valid_r, out_valid_nxt;
  logic [RAW_W-1:0]         out_raw_r;
  logic signed [DIST_W-1:0] out_dist_r;
  status_t                  out_status_r;

  logic                     in_acc;
  logic                     p1_adv;
  logic [RAW_W-1:0]         raw_asm;
  logic [NUM_W-1:0]         num;
  logic signed [DIST_W-1:0] conv_dist;
  logic signed [DIST_W-1:0] dist_sel;

  assign in_stall = p1_valid_r && out_valid_r && out_stall;
  assign in_acc   = in_valid && !in_stall;
  assign p1_adv   = p1_valid_r && (!out_valid_r || !out_stall);

  assign raw_asm = {in_rx_byte[TOP_W-1:0], mid_bits_r, low_bits_r};

  always_comb begin
    low_bits_nxt  = low_bits_r;
    mid_bits_nxt  = mid_bits_r;
    err_cnt_nxt   = err_cnt_r;
    last_good_nxt = last_good_r;
    p1_nxt        = p1_r;
    p1_valid_nxt  = p1_valid_r;
    num           = NUM_W'(raw_asm) * NUM_W'(SCALE_MUL) - NUM_W'(ZERO_OFFSET);

    if (p1_adv) begin
      p1_valid_nxt = 1'b0;
    end

    if (in_acc) begin
      if (!in_rx_byte[TAG_HIGH_BIT]) begin
        if (in_rx_byte[TAG_MID_BIT]) begin
          mid_bits_nxt = in_rx_byte[PART_W-1:0];
        end else begin
          low_bits_nxt = in_rx_byte[PART_W-1:0];
        end
      end else begin
        p1_valid_nxt    = 1'b1;
        p1_nxt.raw      = raw_asm;
        p1_nxt.sel_high = last_good_r > MIDDLE_CODE;
        p1_nxt.neg      = num[NUM_W-1];
        p1_nxt.mag      = num[NUM_W-1] ? MAG_W'(-num) : MAG_W'(num);
        if (raw_asm == ERROR_CODE) begin
          if (err_cnt_r > err_limit_r) begin
            p1_nxt.status = ST_REPORTED;
          end else begin
            p1_nxt.status = ST_IGNORED;
            if (err_cnt_r != {CNT_W{1'b1}}) begin
              err_cnt_nxt = err_cnt_r + CNT_W'(1);
            end
          end
        end else begin
          p1_nxt.status = ST_VALID;
          err_cnt_nxt   = '0;
          last_good_nxt = raw_asm;
        end
      end
    end
  end

  ldfd_conv #(
    .FRAC_BITS (FRAC_BITS)
  ) u_conv (
    .neg    (p1_r.neg),
    .mag    (p1_r.mag),
    .q_dist (conv_dist)
  );

  always_comb begin
    unique case (p1_r.status)
      ST_VALID:    dist_sel = conv_dist;
      ST_REPORTED: dist_sel = p1_r.sel_high ? high_dist_r : low_dist_r;
      default:     dist_sel = held_dist_r;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (p1_adv) begin
      out_valid_nxt = 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      err_limit_r <= ERR_LIMIT_RST;
      high_dist_r <= HIGH_DIST_RST;
      low_dist_r  <= LOW_DIST_RST;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        CFG_ERR_LIMIT: err_limit_r <= cfg_wr_data[CNT_W-1:0];
        CFG_HIGH_DIST: high_dist_r <= cfg_wr_data[DIST_W-1:0];
        CFG_LOW_DIST:  low_dist_r  <= cfg_wr_data[DIST_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      low_bits_r  <= '0;
      mid_bits_r  <= '0;
      err_cnt_r   <= '0;
      last_good_r <= '0;
      held_dist_r <= '0;
      p1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      low_bits_r  <= low_bits_nxt;
      mid_bits_r  <= mid_bits_nxt;
      err_cnt_r   <= err_cnt_nxt;
      last_good_r <= last_good_nxt;
      p1_valid_r  <= p1_valid_nxt;
      out_valid_r <= out_valid_nxt;
      if (p1_adv) begin
        held_dist_r <= dist_sel;
      end
    end
  end

  always_ff @(posedge clk) begin
    p1_r <= p1_nxt;
    if (p1_adv) begin
      out_raw_r    <= p1_r.raw;
      out_dist_r   <= dist_sel;
      out_status_r <= p1_r.status;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_raw_value     = out_raw_r;
  assign out_distance_q8   = out_dist_r;
  assign out_sample_status = out_status_r;

endmodule

`default_nettype wire

@@ rtl/ldfd_checker.sv @@
// Port-level checks for the laser distance frame decoder, bound to the top level.
`default_nettype none

module ldfd_checker (
  input wire logic                            clk,
  input wire logic                            rst_n,
  input wire logic                            in_valid,
  input wire logic                            in_stall,
  input wire logic [ldfd_pkg::RX_W-1:0]       in_rx_byte,
  input wire logic                            out_valid,
  input wire logic                            out_stall,
  input wire logic [ldfd_pkg::RAW_W-1:0]      out_raw_value,
  input wire logic [ldfd_pkg::DIST_W-1:0]     out_distance_q8,
  input wire logic [1:0]                      out_sample_status,
  input wire logic                            cfg_wr_en,
  input wire logic [ldfd_pkg::CFG_IDX_W-1:0]  cfg_index,
  input wire logic [ldfd_pkg::CFG_W-1:0]      cfg_wr_data
);
  import ldfd_pkg::*;

  logic [DIST_W-1:0] last_dist_r;
  logic              cfg_seen;

  assign cfg_seen = cfg_wr_en && (cfg_index != CFG_ERR_LIMIT || cfg_wr_data != '0);

  // distance of the most recently delivered result
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_dist_r <= '0;
    end else if (out_valid && !out_stall) begin
      last_dist_r <= out_distance_q8;
    end
  end

  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_sample_status == ST_VALID || out_sample_status == ST_REPORTED ||
                   out_sample_status == ST_IGNORED))
    else $error("undefined sample status");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_raw_value) &&
                               $stable(out_distance_q8) && $stable(out_sample_status))
    else $error("stalled result changed");

  a_ignored_holds: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_sample_status == ST_IGNORED |-> out_distance_q8 == last_dist_r)
    else $error("ignored error sample did not repeat held distance");

  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_valid && !in_stall && in_rx_byte[TAG_HIGH_BIT], 2))
    else $error("result appeared without a completing byte two cycles earlier");

  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid && out_stall && !cfg_seen || in_stall && out_valid && out_stall)
    else $error("input stalled while output is free");

endmodule

bind laser_distance_frame_decoder ldfd_checker u_ldfd_checker (.*);

`default_nettype wire

@@ verif/tb_laser_distance_frame_decoder.sv @@
// Self-checking testbench for the laser distance frame decoder: directed table, then random frames.
`timescale 1ns / 1ps

module tb_laser_distance_frame_decoder;
  import ldfd_pkg::*;

  localparam int CYCLE_LIMIT   = 200000;
  localparam int SETTLE_CYCLES = 4;
  localparam int DRAIN_CYCLES  = 8;
  localparam int PHASE_ITEMS   = 132;
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

  // Byte pattern of the sensor error code, split by part
  localparam logic [RX_W-1:0] ERR_LOW_BYTE = {2'b00, ERROR_CODE[5:0]};
  localparam logic [RX_W-1:0] ERR_MID_BYTE = {2'b01, ERROR_CODE[11:6]};

  typedef struct packed {
    logic [RAW_W-1:0]  raw;
    logic [DIST_W-1:0] dist_q8;
    status_t           status;
  } sample_t;

  typedef struct packed {
    bit                   is_reg;
    logic [CFG_IDX_W-1:0] idx;
    logic [CFG_W-1:0]     data;
    bit                   known;
    sample_t              s;
  } step_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic [RX_W-1:0] in_rx_byte = '0;
  logic out_stall = 1'b0;
  logic cfg_wr_en = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0] cfg_wr_data = '0;
  logic in_stall;
  logic out_valid;
  logic [RAW_W-1:0] out_raw_value;
  logic signed [DIST_W-1:0] out_distance_q8;
  logic [1:0] out_sample_status;

  laser_distance_frame_decoder dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_rx_byte       (in_rx_byte),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_raw_value    (out_raw_value),
    .out_distance_q8  (out_distance_q8),
    .out_sample_status(out_sample_status),
    .cfg_wr_en        (cfg_wr_en),
    .cfg_index        (cfg_index),
    .cfg_wr_data      (cfg_wr_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Decoder mirror: configuration and state
  logic [CNT_W-1:0]  lim_cfg = ERR_LIMIT_RST;
  logic [DIST_W-1:0] high_dist_cfg = HIGH_DIST_RST;
  logic [DIST_W-1:0] low_dist_cfg = LOW_DIST_RST;
  logic [PART_W-1:0] low_part = '0;
  logic [PART_W-1:0] mid_part = '0;
  logic [CNT_W-1:0]  err_count = '0;
  logic [RAW_W-1:0]  last_good = '0;
  logic [DIST_W-1:0] held_dist = '0;

  sample_t pending_samples[$];
  sample_t want;
  int n_fail = 0;
  int cycle_count = 0;
  int in_idle_pct = 0;
  int out_stall_pct = 0;

  // ((raw*102/65520) - 1) / 2 in Q8, rounded half away from zero, saturated
  function automatic logic [DIST_W-1:0] raw_to_q8(logic [RAW_W-1:0] raw);
    longint num;
    longint den;
    longint q;
    num = (longint'(raw) * 102 - 65520) * (longint'(1) << FRAC_BITS_DEF);
    den = 131040;
    if (num >= 0) q = (num + den / 2) / den;
    else q = -((-num + den / 2) / den);
    if (q > 32767) q = 32767;
    if (q < -32768) q = -32768;
    return q[DIST_W-1:0];
  endfunction

  task automatic decode_byte(input logic [RX_W-1:0] b, output bit has_sample,
                             output sample_t s);
    logic [RAW_W-1:0] raw;
    has_sample = 1'b0;
    s = '0;
    if (!b[TAG_HIGH_BIT]) begin
      if (b[TAG_MID_BIT]) mid_part = b[PART_W-1:0];
      else low_part = b[PART_W-1:0];
    end else begin
      raw = {b[TOP_W-1:0], mid_part, low_part};
      if (raw == ERROR_CODE) begin
        if (err_count > lim_cfg) begin
          held_dist = (last_good > MIDDLE_CODE) ? high_dist_cfg : low_dist_cfg;
          s.status = ST_REPORTED;
        end else begin
          if (err_count != '1) err_count = err_count + 1'b1;
          s.status = ST_IGNORED;
        end
      end else begin
        held_dist = raw_to_q8(raw);
        last_good = raw;
        err_count = '0;
        s.status = ST_VALID;
      end
      s.raw = raw;
      s.dist_q8 = held_dist;
      has_sample = 1'b1;
    end
  endtask

  // One request on the input channel; a known result replaces the predicted one
  task automatic push_byte(input logic [RX_W-1:0] b, input bit known, input sample_t ks);
    bit has_sample;
    sample_t s;
    while ($urandom_range(0, 99) < in_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_rx_byte <= b;
    do @(posedge clk); while (in_stall);
    decode_byte(b, has_sample, s);
    if (has_sample) pending_samples.push_back(known ? ks : s);
  endtask

  task automatic send_byte(input logic [RX_W-1:0] b);
    push_byte(b, 1'b0, '0);
  endtask

  // Registers change only with the pipeline empty
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] v);
    in_valid <= 1'b0;
    while (pending_samples.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    case (idx)
      CFG_ERR_LIMIT: lim_cfg = v[CNT_W-1:0];
      CFG_HIGH_DIST: high_dist_cfg = v;
      CFG_LOW_DIST:  low_dist_cfg = v;
      default: ;
    endcase
  endtask

  function automatic step_t put_byte(logic [RX_W-1:0] b);
    step_t r;
    r = '0;
    r.data = {8'h00, b};
    return r;
  endfunction

  function automatic step_t put_known(logic [RX_W-1:0] b, logic [RAW_W-1:0] raw,
                                     logic [DIST_W-1:0] dq, status_t st);
    step_t r;
    r = put_byte(b);
    r.known = 1'b1;
    r.s.raw = raw;
    r.s.dist_q8 = dq;
    r.s.status = st;
    return r;
  endfunction

  function automatic step_t put_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] v);
    step_t r;
    r = '0;
    r.is_reg = 1'b1;
    r.idx = idx;
    r.data = v;
    return r;
  endfunction

  // Mostly whole frames with random content, error bursts and some loose bytes
  task automatic send_random_traffic(input int n_items);
    int sent;
    int pick;
    int burst;
    sent = 0;
    while (sent < n_items) begin
      pick = $urandom_range(0, 99);
      if (pick < 60) begin
        send_byte({2'b00, 6'($urandom)});
        send_byte({2'b01, 6'($urandom)});
        send_byte({1'b1, 3'($urandom), 4'($urandom)});
        sent += 3;
      end else if (pick < 85) begin
        burst = $urandom_range(1, (lim_cfg < 8) ? int'(lim_cfg) + 3 : 10);
        for (int i = 0; i < burst; i++) begin
          // stored parts persist, so a lone high byte can repeat the error code
          if (i == 0 || $urandom_range(0, 1)) begin
            send_byte(ERR_LOW_BYTE);
            send_byte(ERR_MID_BYTE);
            sent += 2;
          end
          send_byte({1'b1, 3'($urandom), 4'hF});
          sent++;
        end
      end else begin
        repeat ($urandom_range(1, 4)) begin
          send_byte(8'($urandom));
          sent++;
        end
      end
    end
  endtask

  always @(posedge clk) begin
    out_stall <= rst_n && ($urandom_range(0, 99) < out_stall_pct);
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (pending_samples.size() == 0) begin
        $error("unexpected result request: raw_value %h", out_raw_value);
        n_fail++;
      end else begin
        want = pending_samples.pop_front();
        if (out_raw_value !== want.raw) begin
          $error("raw_value: expected %h, got %h", want.raw, out_raw_value);
          n_fail++;
        end
        if (out_distance_q8 !== want.dist_q8) begin
          $error("distance_q8: expected %0d, got %0d", $signed(want.dist_q8),
                 out_distance_q8);
          n_fail++;
        end
        if (out_sample_status !== want.status) begin
          $error("sample_status: expected %0d, got %0d", want.status, out_sample_status);
          n_fail++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("laser_distance_frame_decoder test failed");
      $finish;
    end
  end

  initial begin
    step_t plan[$];
    step_t r;
    plan = '{
      put_known(8'h80, 16'h0000, 16'hFF80, ST_VALID),
      put_byte(8'h3F), put_byte(8'h7F),
      put_known(8'h8F, 16'hFFFF, 16'd12931, ST_VALID),
      put_byte(8'hC0),
      // limit 0: first error ignored, second reported; last good is low
      put_reg(CFG_ERR_LIMIT, 16'd0),
      put_byte(ERR_LOW_BYTE), put_byte(ERR_MID_BYTE), put_byte(8'hBF),
      put_known(8'hFF, ERROR_CODE, LOW_DIST_RST, ST_REPORTED),
      put_reg(CFG_HIGH_DIST, 16'h8000), put_reg(CFG_LOW_DIST, 16'h7FFF),
      put_byte(8'h00), put_byte(8'h40), put_byte(8'h88),
      put_byte(ERR_LOW_BYTE), put_byte(ERR_MID_BYTE), put_byte(8'h8F),
      put_known(8'h8F, ERROR_CODE, 16'h8000, ST_REPORTED),
      // last good exactly at the middle code picks the low distance
      put_byte(8'h1D), put_byte(8'h7F), put_byte(8'h87),
      put_byte(ERR_LOW_BYTE), put_byte(ERR_MID_BYTE), put_byte(8'hCF),
      put_known(8'hEF, ERROR_CODE, 16'h7FFF, ST_REPORTED),
      put_reg(CFG_UNUSED, 16'hFFFF),
      // limit 255: errors are never reported
      put_reg(CFG_ERR_LIMIT, 16'd255),
      put_byte(8'h8F)
    };

    in_idle_pct = 16;
    out_stall_pct = 58;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (plan[i]) begin
      r = plan[i];
      if (r.is_reg) write_reg(r.idx, r.data);
      else push_byte(r.data[RX_W-1:0], r.known, r.s);
    end

    for (int p = 0; p < 6; p++) begin
      in_idle_pct = (p < 2) ? 16 : (p < 4) ? 58 : 0;
      out_stall_pct = (p < 2) ? 58 : (p < 4) ? 16 : 0;
      case (p)
        0: begin
          write_reg(CFG_ERR_LIMIT, 16'd0);
          write_reg(CFG_HIGH_DIST, 16'h7FFF);
          write_reg(CFG_LOW_DIST, 16'h8000);
        end
        1: begin
          write_reg(CFG_ERR_LIMIT, 16'd255);
          write_reg(CFG_HIGH_DIST, 16'($urandom));
          write_reg(CFG_LOW_DIST, 16'($urandom));
        end
        default: begin
          write_reg(CFG_ERR_LIMIT, {8'($urandom), 8'($urandom_range(0, 6))});
          write_reg(CFG_HIGH_DIST, 16'($urandom));
          write_reg(CFG_LOW_DIST, 16'($urandom));
        end
      endcase
      send_random_traffic(PHASE_ITEMS);
    end

    in_valid <= 1'b0;
    while (pending_samples.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (n_fail == 0) begin
      $display("laser_distance_frame_decoder test passed");
    end else begin
      $display("laser_distance_frame_decoder test failed");
    end
    $finish;
  end

endmodule
